/* rtl/core/lpg_pkg.sv */
package lpg_pkg;

   localparam int CoordWidth = 16;
   localparam int DiffWidth = 17;
   localparam int ErrWidth = 19;

   localparam logic ACTION_STEP = 1'b0;
   localparam logic ACTION_START = 1'b1;

   localparam logic [DiffWidth-1:0] MaxPointsReset = 17'h10000;

   typedef struct packed {
      logic action;
      logic signed [CoordWidth-1:0] start_x;
      logic signed [CoordWidth-1:0] start_y;
      logic signed [CoordWidth-1:0] end_x;
      logic signed [CoordWidth-1:0] end_y;
   } req_item_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x_pos;
      logic signed [CoordWidth-1:0] y_pos;
      logic valid_res;
      logic last;
   } rsp_item_type;

endpackage

/* rtl/core/lpg_stream_if.sv */
interface lpg_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/lpg_tracer.sv */
module lpg_tracer (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  lpg_pkg::req_item_type item,
   input  logic [16:0] max_points,
   output lpg_pkg::rsp_item_type result
);
   import lpg_pkg::*;

   logic signed [CoordWidth-1:0] cur_x_ff, cur_x_in;
   logic signed [CoordWidth-1:0] cur_y_ff, cur_y_in;
   logic signed [ErrWidth-1:0] err_ff, err_in;
   logic [DiffWidth-1:0] major_ff, major_in;
   logic [DiffWidth-1:0] minor_ff, minor_in;
   logic x_major_ff, x_major_in;
   logic [1:0] signs_ff, signs_in;
   logic [DiffWidth-1:0] left_ff, left_in;

   logic signed [DiffWidth-1:0] dx;
   logic signed [DiffWidth-1:0] dy;
   logic [DiffWidth-1:0] adx;
   logic [DiffWidth-1:0] ady;
   logic [DiffWidth-1:0] s_major;
   logic [DiffWidth-1:0] s_minor;
   logic [DiffWidth-1:0] limit;
   logic [DiffWidth-1:0] limit_m1;
   logic minor_step;
   logic [CoordWidth-1:0] x_inc;
   logic [CoordWidth-1:0] y_inc;
   logic signed [ErrWidth-1:0] major_sub;

   always_comb begin
      dx = {item.end_x[CoordWidth-1], item.end_x} - {item.start_x[CoordWidth-1], item.start_x};
      dy = {item.end_y[CoordWidth-1], item.end_y} - {item.start_y[CoordWidth-1], item.start_y};
      adx = dx[DiffWidth-1] ? DiffWidth'(-dx) : DiffWidth'(dx);
      ady = dy[DiffWidth-1] ? DiffWidth'(-dy) : DiffWidth'(dy);
      if (adx > ady) begin
         s_major = adx;
         s_minor = ady;
      end else begin
         s_major = ady;
         s_minor = adx;
      end
      limit = (max_points == '0) ? 17'd1 : max_points;
      limit_m1 = (max_points == '0) ? 17'd0 : DiffWidth'(max_points - 17'd1);

      minor_step = !err_ff[ErrWidth-1] && (err_ff != '0);
      x_inc = signs_ff[0] ? 16'hFFFF : 16'h0001;
      y_inc = signs_ff[1] ? 16'hFFFF : 16'h0001;
      major_sub = minor_step ? ErrWidth'({1'b0, major_ff, 1'b0}) : '0;

      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in = err_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      x_major_in = x_major_ff;
      signs_in = signs_ff;
      left_in = left_ff;
      result = '0;

      if (item.action == ACTION_START) begin
         signs_in = {dy[DiffWidth-1], dx[DiffWidth-1]};
         x_major_in = (adx > ady);
         major_in = s_major;
         minor_in = s_minor;
         err_in = ErrWidth'({1'b0, s_minor, 1'b0}) - ErrWidth'({2'b00, s_major});
         cur_x_in = item.start_x;
         cur_y_in = item.start_y;
         left_in = (s_major >= limit) ? limit_m1 : s_major;
         result.x_pos = item.start_x;
         result.y_pos = item.start_y;
         result.valid_res = 1'b1;
         result.last = (left_in == '0);
      end else if (left_ff != '0) begin
         if (x_major_ff) begin
            cur_x_in = cur_x_ff + x_inc;
            if (minor_step) begin
               cur_y_in = cur_y_ff + y_inc;
            end
         end else begin
            cur_y_in = cur_y_ff + y_inc;
            if (minor_step) begin
               cur_x_in = cur_x_ff + x_inc;
            end
         end
         err_in = err_ff + ErrWidth'({1'b0, minor_ff, 1'b0}) - major_sub;
         left_in = DiffWidth'(left_ff - 17'd1);
         result.x_pos = cur_x_in;
         result.y_pos = cur_y_in;
         result.valid_res = 1'b1;
         result.last = (left_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         err_ff <= '0;
         major_ff <= '0;
         minor_ff <= '0;
         x_major_ff <= 1'b0;
         signs_ff <= '0;
         left_ff <= '0;
      end else if (advance) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         err_ff <= err_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         x_major_ff <= x_major_in;
         signs_ff <= signs_in;
         left_ff <= left_in;
      end
   end

endmodule

/* rtl/core/line_point_generator.sv */
// Pipeline: a request transaction accepted into the first stage is registered there, and
// its result is registered in the response register when the first stage advances.
// Throughput: one transaction per cycle; the request side stays ready while the
// response register is free or is being taken in the same cycle.
// Reset: synchronous, active high; clears the line state and both pipeline
// valid bits, and sets max_points to 65536.
module line_point_generator (
   input  logic clock,
   input  logic reset,
   lpg_stream_if.sink req_chan,
   lpg_stream_if.source rsp_chan,
   input  logic csr_write_en,
   input  logic [16:0] csr_write_data
);
   import lpg_pkg::*;

   logic s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type next_result;
   logic [DiffWidth-1:0] max_points_ff;
   logic advance;
   logic req_accept;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   lpg_tracer u_tracer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (s1_item_ff),
      .max_points (max_points_ff),
      .result     (next_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_points_ff <= MaxPointsReset;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            max_points_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_item_ff <= next_result;
      end
   end

   // An empty response carries no coordinates.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.valid_res |->
         rsp_item_ff.x_pos == '0 && rsp_item_ff.y_pos == '0 && !rsp_item_ff.last)
      else $error("empty response carries data");

   // The last flag only marks a real point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.last |-> rsp_item_ff.valid_res)
      else $error("last set without a point");

   // A transaction that leaves the first stage shows up as a response next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced transaction lost");

   // A start transaction always produces a point.
   assert property (@(posedge clock) disable iff (reset)
      advance && s1_item_ff.action == ACTION_START |=> rsp_item_ff.valid_res)
      else $error("start transaction without a point");

endmodule

/* bench/lpg_point_checker.sv */
`timescale 1ns / 1ps

module lpg_point_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  lpg_pkg::req_item_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  lpg_pkg::rsp_item_type rsp_payload,
   input  logic csr_write_en,
   input  logic [16:0] csr_write_data,
   output int mismatch_count,
   output int points_pending,
   output int points_checked
);
   import lpg_pkg::*;

   logic signed [CoordWidth-1:0] cur_x;
   logic signed [CoordWidth-1:0] cur_y;
   logic signed [ErrWidth-1:0] err_term;
   logic [DiffWidth-1:0] major_diff;
   logic [DiffWidth-1:0] minor_diff;
   logic x_major;
   logic x_neg;
   logic y_neg;
   logic [DiffWidth-1:0] points_left;
   logic [DiffWidth-1:0] max_pts;

   rsp_item_type expected_points[$];
   int mismatches;
   int checked;

   function automatic rsp_item_type predict_point(input req_item_type rq);
      rsp_item_type pt;
      logic signed [DiffWidth-1:0] dx;
      logic signed [DiffWidth-1:0] dy;
      logic [DiffWidth-1:0] adx;
      logic [DiffWidth-1:0] ady;
      logic [DiffWidth-1:0] limit;
      logic [DiffWidth-1:0] span;
      logic minor_step;
      pt = '0;
      if (rq.action == ACTION_START) begin
         dx = {rq.end_x[CoordWidth-1], rq.end_x} - {rq.start_x[CoordWidth-1], rq.start_x};
         dy = {rq.end_y[CoordWidth-1], rq.end_y} - {rq.start_y[CoordWidth-1], rq.start_y};
         x_neg = dx[DiffWidth-1];
         y_neg = dy[DiffWidth-1];
         adx = x_neg ? -dx : dx;
         ady = y_neg ? -dy : dy;
         x_major = adx > ady;
         major_diff = x_major ? adx : ady;
         minor_diff = x_major ? ady : adx;
         err_term = {1'b0, minor_diff, 1'b0} - {2'b00, major_diff};
         cur_x = rq.start_x;
         cur_y = rq.start_y;
         limit = (max_pts == '0) ? DiffWidth'(1) : max_pts;
         span = major_diff + 1'b1;
         points_left = ((span > limit) ? limit : span) - 1'b1;
         pt.x_pos = cur_x;
         pt.y_pos = cur_y;
         pt.valid_res = 1'b1;
         pt.last = (points_left == '0);
      end else if (points_left != '0) begin
         minor_step = err_term > 0;
         if (x_major || minor_step) begin
            cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
         end
         if (!x_major || minor_step) begin
            cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
         end
         if (minor_step) begin
            err_term = err_term - {1'b0, major_diff, 1'b0};
         end
         err_term = err_term + {1'b0, minor_diff, 1'b0};
         points_left = points_left - 1'b1;
         pt.x_pos = cur_x;
         pt.y_pos = cur_y;
         pt.valid_res = 1'b1;
         pt.last = (points_left == '0);
      end
      return pt;
   endfunction

   always @(posedge clock) begin : track_points
      rsp_item_type want;
      if (reset) begin
         cur_x = '0;
         cur_y = '0;
         err_term = '0;
         major_diff = '0;
         minor_diff = '0;
         x_major = 1'b0;
         x_neg = 1'b0;
         y_neg = 1'b0;
         points_left = '0;
         max_pts = MaxPointsReset;
         expected_points.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         if (csr_write_en) begin
            max_pts = csr_write_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected response transaction x=%0d y=%0d valid=%0b last=%0b",
                        $time, rsp_payload.x_pos, rsp_payload.y_pos,
                        rsp_payload.valid_res, rsp_payload.last);
               mismatches++;
            end else begin
               want = expected_points.pop_front();
               checked++;
               if (rsp_payload.x_pos !== want.x_pos || rsp_payload.y_pos !== want.y_pos ||
                   rsp_payload.valid_res !== want.valid_res ||
                   rsp_payload.last !== want.last) begin
                  $display("%0t: point mismatch, expected x=%0d y=%0d valid=%0b last=%0b",
                           $time, want.x_pos, want.y_pos, want.valid_res, want.last);
                  $display("%0t:                 actual   x=%0d y=%0d valid=%0b last=%0b",
                           $time, rsp_payload.x_pos, rsp_payload.y_pos,
                           rsp_payload.valid_res, rsp_payload.last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_points.push_back(predict_point(req_payload));
         end
      end
      mismatch_count <= mismatches;
      points_pending <= expected_points.size();
      points_checked <= checked;
   end

endmodule

/* bench/tb_line_point_generator.sv */
`timescale 1ns / 1ps

module tb_line_point_generator;
   import lpg_pkg::*;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [16:0] csr_write_data;

   lpg_stream_if #(.payload_type(req_item_type)) req_chan ();
   lpg_stream_if #(.payload_type(rsp_item_type)) rsp_chan ();

   int mismatch_count;
   int points_pending;
   int points_checked;

   bit sender_idles;
   bit receiver_idles;
   int hold_requests;
   int items_sent;
   int lines_started;
   int settings_used;
   int max_points_now;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   line_point_generator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   lpg_point_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .points_pending (points_pending),
      .points_checked (points_checked)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > 32767) begin
         return 32767;
      end else if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   function automatic int random_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 99) < 30) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_step();
      req_item_type it;
      it.action = ACTION_STEP;
      it.start_x = 16'($urandom);
      it.start_y = 16'($urandom);
      it.end_x = 16'($urandom);
      it.end_y = 16'($urandom);
      send_item(it);
   endtask

   task automatic send_start(input int sx, input int sy, input int ex, input int ey);
      req_item_type it;
      it.action = ACTION_START;
      it.start_x = 16'(sx);
      it.start_y = 16'(sy);
      it.end_x = 16'(ex);
      it.end_y = 16'(ey);
      lines_started++;
      send_item(it);
   endtask

   task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                            input int steps);
      send_start(sx, sy, ex, ey);
      repeat (steps) send_step();
   endtask

   // Most lines are short so that they run to their end point and past it.
   task automatic trace_line();
      int kind;
      int spread;
      int sx;
      int sy;
      int ex;
      int ey;
      int adx;
      int ady;
      int npts;
      int limit;
      int steps;
      kind = $urandom_range(0, 99);
      spread = (kind < 75) ? 12 : 300;
      sx = random_coord();
      sy = random_coord();
      if (kind < 93) begin
         ex = clamp_coord(sx + int'($urandom_range(0, 2 * spread)) - spread);
         ey = clamp_coord(sy + int'($urandom_range(0, 2 * spread)) - spread);
      end else begin
         ex = random_coord();
         ey = random_coord();
      end
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      npts = ((adx > ady) ? adx : ady) + 1;
      limit = (max_points_now == 0) ? 1 : max_points_now;
      if (npts > limit) begin
         npts = limit;
      end
      if (npts <= 40 && $urandom_range(0, 99) < 85) begin
         steps = npts - 1 + $urandom_range(0, 2);
      end else begin
         steps = $urandom_range(0, (npts - 1 < 30) ? npts - 1 : 30);
      end
      send_line(sx, sy, ex, ey, steps);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_max_points(input int value);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= 17'(value);
      max_points_now = value;
      settings_used++;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin : rsp_side
      int stall_left;
      int holds_served;
      stall_left = 0;
      holds_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            stall_left = 250;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap() - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : req_side
      int settings[7];
      int phase_end;
      settings = '{65536, 1, 0, 4, 131071, 2, 65536};
      settings[5] = $urandom_range(2, 24);
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      hold_requests = 0;
      items_sent = 0;
      lines_started = 0;
      settings_used = 0;
      max_points_now = 65536;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_step();
      send_line(-32768, -32768, 32767, 32767, 2);
      send_line(32767, -32768, -32768, 32767, 2);
      send_line(100, -7, 100, -7, 1);
      send_line(0, 0, 3, 1, 4);
      send_line(-5, 10, -3, 4, 2);
      send_line(32767, 32767, 32760, 32767, 3);
      send_line(-32768, 5, -32768, -2, 2);

      for (int p = 0; p < 7; p++) begin
         set_max_points(settings[p]);
         sender_idles = (p % 2) == 0;
         receiver_idles = (p % 3) != 1;
         if (p == 3) begin
            sender_idles = 1'b0;
            hold_requests++;
         end
         phase_end = items_sent + 220;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 6) begin
               send_step();
            end else begin
               trace_line();
            end
            if ($urandom_range(0, 99) < 2) begin
               drain();
            end
         end
      end

      req_chan.valid <= 1'b0;
      drain();
      $display("Sent %0d request transactions, %0d of them line starts, %s %0d %s",
               items_sent, lines_started, "under", settings_used, "max_points settings.");
      $display("Checked %0d response transactions against the predicted points.", points_checked);
      if (mismatch_count == 0 && points_pending == 0) begin
         $display("line_point_generator verification clean");
      end else begin
         $display("line_point_generator verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("line_point_generator verification failed");
      $finish;
   end

endmodule
